FILE: rtl/pti_pkg.sv
`timescale 1ns / 1ps

package pti_pkg;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int LETTER_W      = $clog2(ALPHABET_SIZE);
   localparam int ADDR_W        = NODE_W + LETTER_W;
   localparam int LINK_W        = NODE_W + 1;

   localparam logic [7:0] FIRST_LETTER = 8'd97;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_SEARCH = 2'd1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BADCHAR = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic       word_end;
      logic       empty_word;
   } req_item_type;

   typedef struct packed {
      logic       found;
      logic [1:0] status;
   } rsp_item_type;

   // One link slot: the child's node index and the child's word-end mark.
   typedef struct packed {
      logic              mark;
      logic [NODE_W-1:0] child;
   } link_entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      link_entry_type    wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctl_type;

endpackage

FILE: rtl/pti_ram.sv
`timescale 1ns / 1ps

module pti_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:(2**ADDR_W)-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/pti_ctrl.sv
`timescale 1ns / 1ps

module pti_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  pti_pkg::req_item_type   req_item,
   output logic                    rsp_strobe,
   output pti_pkg::rsp_item_type   rsp_item,
   output pti_pkg::ram_ctl_type    ram_ctl,
   input  pti_pkg::link_entry_type link_rd
);

   import pti_pkg::*;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_EXEC  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [NODE_W:0]   free_ff, free_in;
   logic              failed_ff, failed_in;
   logic [1:0]        fail_code_ff, fail_code_in;
   logic              root_mark_ff, root_mark_in;
   req_item_type      item_ff, item_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic              letter_ok_ff, letter_ok_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic [7:0]          diff;
   logic                letter_ok;
   logic [LETTER_W-1:0] letter;
   logic                accept;
   logic                mark_v;
   logic                is_insert;

   always_comb begin
      diff      = req_item.char_code - FIRST_LETTER;
      letter_ok = (req_item.char_code >= FIRST_LETTER) &&
                  ({1'b0, diff} < 9'(ALPHABET_SIZE));
      letter    = diff[LETTER_W-1:0];
      accept    = start && (state_ff == S_IDLE);
      is_insert = (item_ff.req_type == REQ_INSERT);
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      cur_in        = cur_ff;
      free_in       = free_ff;
      failed_in     = failed_ff;
      fail_code_in  = fail_code_ff;
      root_mark_in  = root_mark_ff;
      item_in       = item_ff;
      slot_in       = slot_ff;
      letter_ok_in  = letter_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      mark_v        = 1'b0;

      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = slot_ff;
      ram_ctl.wr_data = '0;
      ram_ctl.rd_addr = {cur_ff, letter};

      unique case (state_ff)
         S_CLEAR: begin
            ram_ctl.wr_en   = 1'b1;
            ram_ctl.wr_addr = clear_addr_ff;
            clear_addr_in   = clear_addr_ff + 1'b1;
            if (clear_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_item.empty_word) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_item_in.status = STATUS_OK;
                  if (req_item.req_type == REQ_INSERT) begin
                     root_mark_in       = 1'b1;
                     rsp_item_in.found  = 1'b1;
                  end else if (req_item.req_type == REQ_SEARCH) begin
                     rsp_item_in.found  = root_mark_ff;
                  end else begin
                     rsp_item_in.found  = 1'b1;
                  end
                  cur_in       = '0;
                  failed_in    = 1'b0;
                  fail_code_in = STATUS_OK;
               end else begin
                  item_in      = req_item;
                  slot_in      = {cur_ff, letter};
                  letter_ok_in = letter_ok;
                  state_in     = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (!letter_ok_ff) begin
               if (!failed_ff) begin
                  failed_in    = 1'b1;
                  fail_code_in = STATUS_BADCHAR;
               end
            end else if (!failed_ff) begin
               if (link_rd.child == '0) begin
                  if (is_insert) begin
                     if (free_ff < (NODE_W + 1)'(NODE_COUNT)) begin
                        ram_ctl.wr_en         = 1'b1;
                        ram_ctl.wr_data.mark  = item_ff.word_end;
                        ram_ctl.wr_data.child = free_ff[NODE_W-1:0];
                        cur_in                = free_ff[NODE_W-1:0];
                        free_in               = free_ff + 1'b1;
                        mark_v                = item_ff.word_end;
                     end else begin
                        failed_in    = 1'b1;
                        fail_code_in = STATUS_FULL;
                     end
                  end else begin
                     failed_in    = 1'b1;
                     fail_code_in = STATUS_OK;
                  end
               end else begin
                  cur_in = link_rd.child;
                  mark_v = link_rd.mark;
                  if (is_insert && item_ff.word_end) begin
                     ram_ctl.wr_en         = 1'b1;
                     ram_ctl.wr_data.mark  = 1'b1;
                     ram_ctl.wr_data.child = link_rd.child;
                  end
               end
            end
            if (item_ff.word_end) begin
               rsp_strobe_in = 1'b1;
               if (failed_in) begin
                  rsp_item_in.found  = 1'b0;
                  rsp_item_in.status = fail_code_in;
               end else begin
                  rsp_item_in.status = STATUS_OK;
                  if (is_insert) begin
                     rsp_item_in.found = 1'b1;
                  end else if (item_ff.req_type == REQ_SEARCH) begin
                     rsp_item_in.found = mark_v;
                  end else begin
                     rsp_item_in.found = 1'b1;
                  end
               end
               cur_in       = '0;
               failed_in    = 1'b0;
               fail_code_in = STATUS_OK;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         cur_ff        <= '0;
         free_ff       <= (NODE_W + 1)'(1);
         failed_ff     <= 1'b0;
         fail_code_ff  <= STATUS_OK;
         root_mark_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         cur_ff        <= cur_in;
         free_ff       <= free_in;
         failed_ff     <= failed_in;
         fail_code_ff  <= fail_code_in;
         root_mark_ff  <= root_mark_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      slot_ff      <= slot_in;
      letter_ok_ff <= letter_ok_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: rtl/prefix_tree_insert_lookup.sv
`timescale 1ns / 1ps
// Response timing: an empty-word item answers in the cycle after it is accepted; a character
// item that ends a word answers from the EXEC state, through the registered response.
// Pacing: a character item holds busy high in the EXEC state, set by the link memory read and
// the write-back that follows it, so no new item is taken until it is done; an empty-word item leaves the block idle.
// Reset: a clearing pass zeroes the link memory, with busy high.
// Results cannot be stalled by the receiver.

module prefix_tree_insert_lookup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pti_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output pti_pkg::rsp_item_type rsp_item
);

   import pti_pkg::*;

   ram_ctl_type    ram_ctl;
   link_entry_type link_rd;
   logic [LINK_W-1:0] rd_data;

   pti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .ram_ctl    (ram_ctl),
      .link_rd    (link_rd)
   );

   pti_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_data),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_data)
   );

   assign link_rd = rd_data;

endmodule
